[rtl/bri_pkg.sv]
// Shared types, constants and the blend function for the bilinear remap core.
// No dependencies; imported by every module of the block except bri_ram.
`timescale 1ns / 1ps

package bri_pkg;

    localparam int PIXEL_W          = 8;
    localparam int ADDR_W           = 19;
    localparam int WEIGHT_W         = 5;
    localparam int TAPS             = 4;
    localparam int WEIGHT_ONE       = 32;
    localparam int FRAME_PIXELS_DEF = 524288;
    localparam int S_TDATA_W        = 120;
    localparam int M_TDATA_W        = 8;

    // item kind carried in tuser
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_REMAP = 1'b1
    } t_func;

    typedef logic [PIXEL_W-1:0]  t_pixel;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [WEIGHT_W-1:0] t_weight;

    // stage 1 payload: fetched taps (a, b, c, d) and weights
    typedef struct packed {
        t_pixel [TAPS-1:0] pix;
        t_weight           wx;
        t_weight           wy;
    } t_fetch;

    // (w*right + (32-w)*left) / 32, never above 255 (sum fits 13 bits)
    function automatic t_pixel blend(input t_weight w, input t_pixel left,
                                     input t_pixel right);
        logic [12:0] sum;
        logic [5:0]  w_inv;
        w_inv = 6'(WEIGHT_ONE) - {1'b0, w};
        sum   = 13'(w) * 13'(right) + 13'(w_inv) * 13'(left);
        return sum[12:5];
    endfunction

endpackage

[rtl/bri_ram.sv]
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`timescale 1ns / 1ps

module bri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bri_fetch.sv]
// Input stage: decodes items, writes the frame store, reads four taps.
// Depends on bri_pkg and bri_ram (four replicated copies of the frame).
`timescale 1ns / 1ps

module bri_fetch import bri_pkg::*; #(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_func                i_func,
    input  t_addr                i_load_addr,
    input  t_pixel               i_load_pixel,
    input  t_addr [TAPS-1:0]     i_index,
    input  t_weight              i_wx,
    input  t_weight              i_wy,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_fetch               o_data
);

    localparam int AW    = (FRAME_PIXELS > 4) ? $clog2(FRAME_PIXELS) : 2;
    localparam int EXT_W = (AW > ADDR_W) ? AW : ADDR_W;

    logic                 r_s1_valid;
    logic [TAPS-1:0]      r_s1_inr;
    t_weight              r_s1_wx;
    t_weight              r_s1_wy;
    logic                 en1;
    logic                 accept;
    logic                 we;
    logic [EXT_W-1:0]     wr_ext;
    logic [TAPS-1:0]      tap_inr;
    t_pixel [TAPS-1:0]    rd_pix;

    assign en1     = !r_s1_valid || i_ready;
    assign o_ready = en1;
    assign accept  = i_valid && en1;
    assign wr_ext  = EXT_W'(i_load_addr);
    assign we      = accept && (i_func == FUNC_LOAD) &&
                     (32'(i_load_addr) < 32'(FRAME_PIXELS));

    for (genvar g = 0; g < TAPS; g++) begin : g_tap
        logic [EXT_W-1:0] rd_ext;
        assign rd_ext     = EXT_W'(i_index[g]);
        assign tap_inr[g] = 32'(i_index[g]) < 32'(FRAME_PIXELS);

        bri_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (FRAME_PIXELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wr_ext[AW-1:0]),
            .i_wdata (i_load_pixel),
            .i_re    (en1),
            .i_raddr (rd_ext[AW-1:0]),
            .o_rdata (rd_pix[g])
        );

        // out-of-range taps read as zero
        assign o_data.pix[g] = r_s1_inr[g] ? rd_pix[g] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_valid && (i_func == FUNC_REMAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_inr <= tap_inr;
            r_s1_wx  <= i_wx;
            r_s1_wy  <= i_wy;
        end
    end

    assign o_valid   = r_s1_valid;
    assign o_data.wx = r_s1_wx;
    assign o_data.wy = r_s1_wy;

endmodule

[rtl/bri_blend.sv]
// Two blend stages: horizontal pair blend, then vertical blend into the output register.
// Depends on bri_pkg (t_fetch, blend).
`timescale 1ns / 1ps

module bri_blend import bri_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_fetch i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_pixel o_pixel
);

    logic    r_s2_valid;
    t_pixel  r_s2_top;
    t_pixel  r_s2_bot;
    t_weight r_s2_wy;
    logic    r_s3_valid;
    t_pixel  r_s3_pixel;
    logic    en2;
    logic    en3;

    assign en3     = !r_s3_valid || i_ready;
    assign en2     = !r_s2_valid || en3;
    assign o_ready = en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (en2) begin
                r_s2_valid <= i_valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_top <= blend(i_data.wx, i_data.pix[0], i_data.pix[1]);
            r_s2_bot <= blend(i_data.wx, i_data.pix[2], i_data.pix[3]);
            r_s2_wy  <= i_data.wy;
        end
        if (en3) begin
            r_s3_pixel <= blend(r_s2_wy, r_s2_top, r_s2_bot);
        end
    end

    assign o_valid = r_s3_valid;
    assign o_pixel = r_s3_pixel;

endmodule

[rtl/bilinear_remap_interpolator_core.sv]
// Top level of the bilinear remap interpolator: stream ports, fetch and blend stages.
// Depends on bri_pkg, bri_fetch, bri_blend (and bri_ram below bri_fetch).
`timescale 1ns / 1ps

// Bilinear remap interpolator. The block holds an 8-bit source frame of
// FRAME_PIXELS entries. An item with tuser = load writes one pixel and gives
// no result; an item with tuser = remap reads four pixels a, b, c, d and
// returns one pixel blended horizontally by weight_x and vertically by
// weight_y (in 32nds, truncating at each step). Throughput is one item per
// clock while the master side accepts, loads and remaps mixed freely; a remap
// result passes the registered store read, pair blend and final blend.
// The four reads per cycle come from four copies of the frame store, each
// written by every load, so the store costs 4 x FRAME_PIXELS x 8 bits. A
// load is visible to a remap accepted in the very next cycle. Taps at an
// address at or above FRAME_PIXELS read as zero, and loads there are dropped.
// The store is not cleared after reset: a remap must only read addresses
// loaded before. Every stage holds under backpressure, and bubbles are
// squeezed out, so an input item is still taken while a result waits if any stage is empty.

module bilinear_remap_interpolator_core import bri_pkg::*; #(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata, low bit up: load_addr[18:0], load_pixel[26:19], index_a[45:27],
    // index_b[64:46], index_c[83:65], index_d[102:84], weight_x[107:103],
    // weight_y[112:108], zero fill [119:113]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: func[0] (0 load, 1 remap)
    input  logic                 i_s_tuser,
    // master side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata: out_pixel[7:0]
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    t_func            func;
    t_addr [TAPS-1:0] index;
    logic             fetch_valid;
    logic             blend_ready;
    t_fetch           fetch_data;

    assign func     = t_func'(i_s_tuser);
    assign index[0] = i_s_tdata[45:27];
    assign index[1] = i_s_tdata[64:46];
    assign index[2] = i_s_tdata[83:65];
    assign index[3] = i_s_tdata[102:84];

    // stage 1: store write / four-tap read
    bri_fetch #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_fetch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_func       (func),
        .i_load_addr  (i_s_tdata[18:0]),
        .i_load_pixel (i_s_tdata[26:19]),
        .i_index      (index),
        .i_wx         (i_s_tdata[107:103]),
        .i_wy         (i_s_tdata[112:108]),
        .o_valid      (fetch_valid),
        .i_ready      (blend_ready),
        .o_data       (fetch_data)
    );

    // stages 2 and 3: pair blends, then the vertical blend
    bri_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fetch_valid),
        .o_ready (blend_ready),
        .i_data  (fetch_data),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_pixel (o_m_tdata)
    );

    // an empty output register means every stage can move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output register empty");

    // no result right out of reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a load item never enters the blend pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (func == FUNC_LOAD)) |=> !fetch_valid)
        else $error("load item produced a pipeline entry");

endmodule
